// File: rtl/grid_fov_slope_raycast_defines.svh
// ---------------------------------------------------------------------------
// grid_fov_slope_raycast assertion macros
// Shorthand for clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef GRID_FOV_SLOPE_RAYCAST_DEFINES_SVH
`define GRID_FOV_SLOPE_RAYCAST_DEFINES_SVH

// same-cycle implication
`define GFSR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GFSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gfsr_pkg.sv
// ---------------------------------------------------------------------------
// gfsr_pkg
// Types, constants and helper functions for the slope raycast field-of-view.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfsr_pkg;

   localparam int MAP_LOG2      = 6;
   localparam int MAP_SIZE      = 1 << MAP_LOG2;
   localparam int TILES         = MAP_SIZE * MAP_SIZE;
   localparam int ADDR_W        = 2 * MAP_LOG2;
   localparam int VIEW_BITS_DEF = 8;
   localparam int SLOPES        = 64;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_CAST  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_CLIP_LEFT   = 2'd0;
   localparam logic [1:0] CSR_CLIP_TOP    = 2'd1;
   localparam logic [1:0] CSR_CLIP_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_CLIP_BOTTOM = 2'd3;

   typedef struct packed {
      cmd_type    cmd;
      logic [5:0] pos_x;
      logic [5:0] pos_y;
      logic       opaque;
      logic [7:0] bit_mask;
   } req_type;

   typedef struct packed {
      logic [7:0] view_bits;
      logic       tile_opaque;
   } rsp_type;

   typedef struct packed {
      logic ring_load;
      logic ring_prep;
      logic step;
      logic p_zero;
   } slope_ctrl_type;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
      logic signed [1:0] px;
      logic signed [1:0] py;
   } dir_type;

   // 63 / (2k+1), truncated
   function automatic logic [5:0] q63_of(input logic [5:0] k);
      logic [5:0] q;
      case (k)
         6'd0: q = 6'd63;
         6'd1: q = 6'd21;
         6'd2: q = 6'd12;
         6'd3: q = 6'd9;
         6'd4: q = 6'd7;
         6'd5: q = 6'd5;
         6'd6, 6'd7: q = 6'd4;
         6'd8, 6'd9, 6'd10: q = 6'd3;
         6'd11, 6'd12, 6'd13, 6'd14, 6'd15: q = 6'd2;
         default: q = (k < 6'd32) ? 6'd1 : 6'd0;
      endcase
      return q;
   endfunction

   // slope bits lsb..msb, ends clamped; inverted ranges keep the xor form
   function automatic logic [SLOPES-1:0] srange(input logic signed [9:0] lsb,
                                                input logic signed [9:0] msb);
      logic [5:0]        lo;
      logic [5:0]        hi;
      logic [SLOPES-1:0] r;
      if (lsb < 10'sd0)       lo = 6'd0;
      else if (lsb > 10'sd62) lo = 6'd62;
      else                    lo = lsb[5:0];
      if (msb < 10'sd0)       hi = 6'd0;
      else if (msb > 10'sd63) hi = 6'd63;
      else                    hi = msb[5:0];
      for (int i = 0; i < SLOPES; i++) begin
         r[i] = (i <= int'(hi)) ^ (i < int'(lo));
      end
      return r;
   endfunction

   function automatic dir_type oct_dir(input logic [2:0] oct);
      dir_type d;
      case (oct)
         3'd0: d = '{dx: 2'sd1,  dy: 2'sd0,  px: 2'sd0,  py: 2'sd1};
         3'd1: d = '{dx: 2'sd1,  dy: 2'sd0,  px: 2'sd0,  py: -2'sd1};
         3'd2: d = '{dx: -2'sd1, dy: 2'sd0,  px: 2'sd0,  py: 2'sd1};
         3'd3: d = '{dx: -2'sd1, dy: 2'sd0,  px: 2'sd0,  py: -2'sd1};
         3'd4: d = '{dx: 2'sd0,  dy: 2'sd1,  px: 2'sd1,  py: 2'sd0};
         3'd5: d = '{dx: 2'sd0,  dy: 2'sd1,  px: -2'sd1, py: 2'sd0};
         3'd6: d = '{dx: 2'sd0,  dy: -2'sd1, px: 2'sd1,  py: 2'sd0};
         default: d = '{dx: 2'sd0, dy: -2'sd1, px: -2'sd1, py: 2'sd0};
      endcase
      return d;
   endfunction

endpackage

// File: rtl/gfsr_slope.sv
// ---------------------------------------------------------------------------
// gfsr_slope
// Slope bounds of the tiles of one ring, kept as running quotients of
// 63*(2p-1)/(2d+1) and 63*(2p+1)/(2d-1) with one add and compare per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfsr_slope (
   input  logic                    clock,
   input  gfsr_pkg::slope_ctrl_type ctrl,
   input  logic [5:0]              d,
   output logic signed [9:0]       lo_val,
   output logic signed [9:0]       hi_val
);
   import gfsr_pkg::*;

   logic [6:0]  dlo, dhi;
   logic [5:0]  q63lo_n, q63hi_n;
   logic [12:0] prod_lo, prod_hi;
   logic [5:0]  q63lo_ff, q63hi_ff;
   logic [6:0]  r63lo_ff, r63hi_ff;
   logic [8:0]  lq_ff, hq_ff;
   logic [6:0]  lr_ff, hr_ff;
   logic [6:0]  lq126_ff, hq126_ff, lr126_ff, hr126_ff;
   logic        c2lo, c2hi, clo, chi;
   logic [7:0]  sum_lo, sum_hi;

   assign dlo     = {d, 1'b1};
   assign dhi     = {d - 6'd1, 1'b1};
   assign q63lo_n = q63_of(d);
   assign q63hi_n = q63_of(d - 6'd1);
   assign prod_lo = 13'(q63lo_n) * 13'(dlo);
   assign prod_hi = 13'(q63hi_n) * 13'(dhi);

   assign c2lo   = {r63lo_ff, 1'b0} >= {1'b0, dlo};
   assign c2hi   = {r63hi_ff, 1'b0} >= {1'b0, dhi};
   assign sum_lo = {1'b0, lr_ff} + {1'b0, lr126_ff};
   assign sum_hi = {1'b0, hr_ff} + {1'b0, hr126_ff};
   assign clo    = sum_lo >= {1'b0, dlo};
   assign chi    = sum_hi >= {1'b0, dhi};

   always_ff @(posedge clock) begin
      if (ctrl.ring_load) begin
         q63lo_ff <= q63lo_n;
         q63hi_ff <= q63hi_n;
         r63lo_ff <= 7'(13'd63 - prod_lo);
         r63hi_ff <= 7'(13'd63 - prod_hi);
      end
      if (ctrl.ring_prep) begin
         lq126_ff <= {q63lo_ff, 1'b0} + 7'(c2lo);
         hq126_ff <= {q63hi_ff, 1'b0} + 7'(c2hi);
         lr126_ff <= 7'({r63lo_ff, 1'b0} - (c2lo ? {1'b0, dlo} : 8'd0));
         hr126_ff <= 7'({r63hi_ff, 1'b0} - (c2hi ? {1'b0, dhi} : 8'd0));
         lq_ff    <= 9'(q63lo_ff);
         lr_ff    <= r63lo_ff;
         hq_ff    <= 9'(q63hi_ff);
         hr_ff    <= r63hi_ff;
      end else if (ctrl.step) begin
         if (!ctrl.p_zero) begin
            lq_ff <= lq_ff + 9'(lq126_ff) + 9'(clo);
            lr_ff <= 7'(sum_lo - (clo ? {1'b0, dlo} : 8'd0));
         end
         hq_ff <= hq_ff + 9'(hq126_ff) + 9'(chi);
         hr_ff <= 7'(sum_hi - (chi ? {1'b0, dhi} : 8'd0));
      end
   end

   assign lo_val = ctrl.p_zero ? -$signed({4'b0000, q63lo_ff}) : $signed({1'b0, lq_ff});
   assign hi_val = $signed({1'b0, hq_ff});

endmodule

// File: rtl/grid_fov_slope_raycast.sv
// ---------------------------------------------------------------------------
// grid_fov_slope_raycast
// Tile opacity map and view map with write, clear, cast and read commands.
// ---------------------------------------------------------------------------
//   channel  | dir | ports                          | carries
//   req      | in  | req_valid req_stall req_data   | command item
//   rsp      | out | rsp_valid rsp_stall rsp_data   | one result item per command
//   csr      | in  | csr_we csr_index csr_wdata     | clip rectangle registers
//
// Clear reads every tile in turn and rewrites the view bits of those in the clip.
// Cast reads each tile it walks, with extra steps per ring and per ring edge; the
// pace of both is set by the single read port of the tile memories.
// After reset both memories are swept to zero while req is stalled.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only at its own end.
`timescale 1ns / 1ps
`include "grid_fov_slope_raycast_defines.svh"

module grid_fov_slope_raycast #(
   parameter int VIEW_BITS = gfsr_pkg::VIEW_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gfsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gfsr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [5:0]        csr_wdata
);
   import gfsr_pkg::*;

   typedef enum logic [13:0] {
      ST_INIT    = 14'b00000000000001,
      ST_IDLE    = 14'b00000000000010,
      ST_CLR_RD  = 14'b00000000000100,
      ST_CLR_WR  = 14'b00000000001000,
      ST_READ    = 14'b00000000010000,
      ST_ORG_RD  = 14'b00000000100000,
      ST_ORG_WR  = 14'b00000001000000,
      ST_RING    = 14'b00000010000000,
      ST_RING2   = 14'b00000100000000,
      ST_PREV_RD = 14'b00001000000000,
      ST_PREV_EV = 14'b00010000000000,
      ST_TILE_RD = 14'b00100000000000,
      ST_TILE_EV = 14'b01000000000000,
      ST_DONE    = 14'b10000000000000
   } state_type;

   function automatic logic in_clip_f(input logic signed [7:0] x, input logic signed [7:0] y,
                                      input logic [5:0] l, input logic [5:0] t,
                                      input logic [5:0] r, input logic [5:0] b);
      return (x[7:6] == 2'b00) && (y[7:6] == 2'b00) && (x[5:0] >= l) && (x[5:0] <= r) &&
             (y[5:0] >= t) && (y[5:0] <= b);
   endfunction

   function automatic logic signed [7:0] sx8(input logic signed [1:0] v);
      return {{6{v[1]}}, v};
   endfunction

   state_type state_ff, state_in;
   logic [5:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   cmd_type cmd_ff, cmd_in;
   logic [5:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [VIEW_BITS-1:0] mask_ff, mask_in;
   logic [2:0] oct_ff, oct_in;
   logic [5:0] d_ff, d_in, p_ff, p_in;
   logic [SLOPES-1:0] open_ff, open_in, closed_ff, closed_in;
   logic signed [7:0] rx_ff, rx_in, ry_ff, ry_in, tx_ff, tx_in, ty_ff, ty_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic opq_mem [TILES];
   logic [VIEW_BITS-1:0] view_mem [TILES];
   logic opq_rd_ff;
   logic [VIEW_BITS-1:0] view_rd_ff;
   logic [ADDR_W-1:0] rd_addr, opq_wa, view_wa;
   logic opq_we, opq_wd, view_we;
   logic [VIEW_BITS-1:0] view_wd;
   logic [31:0] view_wide;

   slope_ctrl_type slope_ctrl;
   logic signed [9:0] lo_val, hi_val, hit_lsb, hit_msb, close_lsb, close_msb;
   logic [SLOPES-1:0] hit_set, close_set, closed_nx, open_end;
   dir_type dir, dir0, dir_nx;
   logic signed [7:0] dx8, dy8, px8, py8, prev_x, prev_y, org_x, org_y;
   logic tile_in_clip, prev_in_clip, org_in_clip, sweep_in_clip;
   logic tile_hit, tile_blk, rsp_free;

   gfsr_slope u_slope (
      .clock  (clock),
      .ctrl   (slope_ctrl),
      .d      (d_ff),
      .lo_val (lo_val),
      .hi_val (hi_val)
   );

   always_ff @(posedge clock) begin
      if (opq_we) begin
         opq_mem[opq_wa] <= opq_wd;
      end
      if (view_we) begin
         view_mem[view_wa] <= view_wd;
      end
      opq_rd_ff  <= opq_mem[rd_addr];
      view_rd_ff <= view_mem[rd_addr];
   end

   assign dir    = oct_dir(oct_ff);
   assign dir0   = oct_dir(3'd0);
   assign dir_nx = oct_dir(oct_ff + 3'd1);
   assign dx8    = sx8(dir.dx);
   assign dy8    = sx8(dir.dy);
   assign px8    = sx8(dir.px);
   assign py8    = sx8(dir.py);
   assign prev_x = tx_ff - dx8;
   assign prev_y = ty_ff - dy8;
   assign org_x  = {2'b00, pos_x_ff};
   assign org_y  = {2'b00, pos_y_ff};

   assign tile_in_clip  = in_clip_f(tx_ff, ty_ff, clip_left_ff, clip_top_ff,
                                    clip_right_ff, clip_bottom_ff);
   assign prev_in_clip  = in_clip_f(prev_x, prev_y, clip_left_ff, clip_top_ff,
                                    clip_right_ff, clip_bottom_ff);
   assign org_in_clip   = in_clip_f(org_x, org_y, clip_left_ff, clip_top_ff,
                                    clip_right_ff, clip_bottom_ff);
   assign sweep_in_clip = in_clip_f({2'b00, sweep_ff[5:0]}, {2'b00, sweep_ff[11:6]},
                                    clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff);

   assign hit_lsb   = lo_val - ((p_ff < 6'd11) ? 10'sd1 : 10'sd0);
   assign hit_msb   = hi_val - ((p_ff == 6'd0) ? 10'sd1 : 10'sd0);
   assign close_lsb = (lo_val > $signed({4'b0000, p_ff})) ? lo_val : $signed({4'b0000, p_ff});
   assign close_msb = hi_val - 10'sd1;
   assign hit_set   = srange(hit_lsb, hit_msb);
   assign close_set = srange(close_lsb, close_msb);
   assign tile_hit  = (|(open_ff & hit_set)) && tile_in_clip;
   assign tile_blk  = !tile_in_clip || opq_rd_ff;
   assign closed_nx = tile_blk ? (closed_ff | close_set) : closed_ff;
   assign open_end  = open_ff & ~closed_nx;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign view_wide = 32'(view_rd_ff);

   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      cmd_in      = cmd_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      mask_in     = mask_ff;
      oct_in      = oct_ff;
      d_in        = d_ff;
      p_in        = p_ff;
      open_in     = open_ff;
      closed_in   = closed_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      rsp_data_in = rsp_data_ff;
      rd_addr     = {pos_y_ff, pos_x_ff};
      opq_we      = 1'b0;
      opq_wa      = sweep_ff;
      opq_wd      = 1'b0;
      view_we     = 1'b0;
      view_wa     = sweep_ff;
      view_wd     = '0;
      slope_ctrl  = '{ring_load: 1'b0, ring_prep: 1'b0, step: 1'b0, p_zero: p_ff == 6'd0};
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;

      case (state_ff)
         ST_INIT: begin
            opq_we   = 1'b1;
            view_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (&sweep_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               pos_x_in = req_data.pos_x;
               pos_y_in = req_data.pos_y;
               mask_in  = VIEW_BITS'(req_data.bit_mask);
               sweep_in = '0;
               case (req_data.cmd)
                  CMD_WRITE: begin
                     opq_we   = 1'b1;
                     opq_wa   = {req_data.pos_y, req_data.pos_x};
                     opq_wd   = req_data.opaque;
                     state_in = ST_DONE;
                  end
                  CMD_CLEAR: state_in = ST_CLR_RD;
                  CMD_CAST:  state_in = ST_ORG_RD;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLR_RD: begin
            rd_addr  = sweep_ff;
            state_in = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            view_we  = sweep_in_clip;
            view_wd  = view_rd_ff & ~mask_ff;
            sweep_in = sweep_ff + 1'b1;
            state_in = (&sweep_ff) ? ST_DONE : ST_CLR_RD;
         end
         ST_READ: state_in = ST_DONE;
         ST_ORG_RD: state_in = org_in_clip ? ST_ORG_WR : ST_DONE;
         ST_ORG_WR: begin
            view_we  = 1'b1;
            view_wa  = {pos_y_ff, pos_x_ff};
            view_wd  = view_rd_ff | mask_ff;
            oct_in   = 3'd0;
            open_in  = '1;
            d_in     = 6'd1;
            rx_in    = org_x + sx8(dir0.dx);
            ry_in    = org_y + sx8(dir0.dy);
            state_in = ST_RING;
         end
         ST_RING: begin
            slope_ctrl.ring_load = 1'b1;
            tx_in     = rx_ff;
            ty_in     = ry_ff;
            p_in      = 6'd0;
            closed_in = '0;
            state_in  = ST_RING2;
         end
         ST_RING2: begin
            slope_ctrl.ring_prep = 1'b1;
            state_in = ST_TILE_RD;
         end
         ST_PREV_RD: begin
            rd_addr  = {prev_y[5:0], prev_x[5:0]};
            state_in = ST_PREV_EV;
         end
         ST_PREV_EV: begin
            if (!prev_in_clip || opq_rd_ff) begin
               open_in[SLOPES-1] = 1'b0;
            end
            state_in = ST_TILE_RD;
         end
         ST_TILE_RD: begin
            rd_addr  = {ty_ff[5:0], tx_ff[5:0]};
            state_in = ST_TILE_EV;
         end
         ST_TILE_EV: begin
            view_we   = tile_hit;
            view_wa   = {ty_ff[5:0], tx_ff[5:0]};
            view_wd   = view_rd_ff | mask_ff;
            closed_in = closed_nx;
            if (p_ff == d_ff) begin
               open_in = open_end;
               if (open_end == '0 || d_ff == 6'(MAP_SIZE - 1)) begin
                  if (oct_ff == 3'd7) begin
                     state_in = ST_DONE;
                  end else begin
                     oct_in   = oct_ff + 3'd1;
                     open_in  = '1;
                     d_in     = 6'd1;
                     rx_in    = org_x + sx8(dir_nx.dx);
                     ry_in    = org_y + sx8(dir_nx.dy);
                     state_in = ST_RING;
                  end
               end else begin
                  d_in     = d_ff + 6'd1;
                  rx_in    = rx_ff + dx8;
                  ry_in    = ry_ff + dy8;
                  state_in = ST_RING;
               end
            end else begin
               slope_ctrl.step = 1'b1;
               p_in     = p_ff + 6'd1;
               tx_in    = tx_ff + px8;
               ty_in    = ty_ff + py8;
               state_in = (p_ff + 6'd1 == d_ff) ? ST_PREV_RD : ST_TILE_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.view_bits   = (cmd_ff == CMD_READ) ? view_wide[7:0] : 8'd0;
               rsp_data_in.tile_opaque = (cmd_ff == CMD_READ) ? opq_rd_ff : 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         clip_left_ff   <= 6'd0;
         clip_top_ff    <= 6'd0;
         clip_right_ff  <= 6'd63;
         clip_bottom_ff <= 6'd63;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
               CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata;
               CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
               CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      mask_ff     <= mask_in;
      oct_ff      <= oct_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      open_ff     <= open_in;
      closed_ff   <= closed_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `GFSR_ASSERT_SAME(a_tile_in_ring, state_ff == ST_TILE_EV, p_ff <= d_ff && d_ff != 6'd0,
                     "tile index beyond ring")
   `GFSR_ASSERT_SAME(a_prev_at_edge, state_ff == ST_PREV_RD, p_ff == d_ff,
                     "ring edge read away from last tile")
   `GFSR_ASSERT_NEXT(a_done_loads, state_ff == ST_DONE && rsp_free, rsp_valid_ff,
                     "finished item not presented")
   `GFSR_ASSERT_SAME(a_cast_write_clip, state_ff == ST_TILE_EV && view_we, tile_in_clip,
                     "view write outside clip")

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for grid_fov_slope_raycast. Directed and random command items go
// through the valid/stall request channel. A behavioral model of the opacity
// and view maps, including the octant slope walk of a cast, predicts each
// result item. A checker compares every result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import gfsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 300000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = CSR_CLIP_LEFT;
   logic [5:0] csr_wdata = '0;

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   // shadow of the block's state
   bit       tile_opq [TILES];
   bit [7:0] tile_view [TILES];
   int       clip_l = 0, clip_t = 0, clip_r = 63, clip_b = 63;

   rsp_type pending_rsp [$];

   grid_fov_slope_raycast dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit in_clip(int x, int y);
      return x >= 0 && y >= 0 && x < MAP_SIZE && y < MAP_SIZE &&
             x >= clip_l && x <= clip_r && y >= clip_t && y <= clip_b;
   endfunction

   function automatic bit is_blocking(int x, int y);
      return !in_clip(x, y) || tile_opq[y * MAP_SIZE + x];
   endfunction

   function automatic bit [63:0] slope_bits(int lsb, int msb);
      int lo, hi;
      bit [63:0] lower, upper;
      lo = lsb < 0 ? 0 : (lsb > 62 ? 62 : lsb);
      hi = msb < 0 ? 0 : (msb > 63 ? 63 : msb);
      lower = 64'd1 << lo;
      upper = 64'd1 << hi;
      return upper ^ (upper - 64'd1) ^ (lower - 64'd1);
   endfunction

   function automatic void light_octant(bit [7:0] mask, int cx, int cy,
                                        int dx, int dy, int px, int py);
      bit [63:0] open_set, closed;
      int x, y, lo, hi, lsb, msb;
      open_set = '1;
      for (int d = 1; open_set != 0 && d < MAP_SIZE; d++) begin
         x = cx + d * dx;
         y = cy + d * dy;
         closed = '0;
         for (int p = 0; p <= d; p++) begin
            lo = 63 * (2 * p - 1) / (2 * d + 1);
            hi = 63 * (2 * p + 1) / (2 * d - 1);
            if (p == d && is_blocking(x - dx, y - dy))
               open_set[63] = 1'b0;
            lsb = lo - (p < 11 ? 1 : 0);
            msb = hi - (p == 0 ? 1 : 0);
            if ((open_set & slope_bits(lsb, msb)) != 0 && in_clip(x, y))
               tile_view[y * MAP_SIZE + x] |= mask;
            if (is_blocking(x, y))
               closed |= slope_bits(lo > p ? lo : p, hi - 1);
            x += px;
            y += py;
         end
         open_set &= ~closed;
      end
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      int x, y;
      o = '0;
      x = r.pos_x;
      y = r.pos_y;
      case (r.cmd)
         CMD_WRITE: tile_opq[y * MAP_SIZE + x] = r.opaque;
         CMD_CLEAR: begin
            for (int i = 0; i < TILES; i++)
               if (in_clip(i % MAP_SIZE, i / MAP_SIZE)) tile_view[i] &= ~r.bit_mask;
         end
         CMD_CAST: begin
            if (in_clip(x, y)) begin
               tile_view[y * MAP_SIZE + x] |= r.bit_mask;
               light_octant(r.bit_mask, x, y, 1, 0, 0, 1);
               light_octant(r.bit_mask, x, y, 1, 0, 0, -1);
               light_octant(r.bit_mask, x, y, -1, 0, 0, 1);
               light_octant(r.bit_mask, x, y, -1, 0, 0, -1);
               light_octant(r.bit_mask, x, y, 0, 1, 1, 0);
               light_octant(r.bit_mask, x, y, 0, 1, -1, 0);
               light_octant(r.bit_mask, x, y, 0, -1, 1, 0);
               light_octant(r.bit_mask, x, y, 0, -1, -1, 0);
            end
         end
         default: begin
            o.view_bits   = tile_view[y * MAP_SIZE + x];
            o.tile_opaque = tile_opq[y * MAP_SIZE + x];
         end
      endcase
      return o;
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.view_bits !== want.view_bits ||
                rsp_data.tile_opaque !== want.tile_opaque) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: view_bits exp %h got %h, tile_opaque exp %b got %b",
                           want.view_bits, rsp_data.view_bits,
                           want.tile_opaque, rsp_data.tile_opaque);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(cmd_type cmd, int x, int y, bit opq, bit [7:0] mask);
      req_type r;
      r.cmd = cmd;
      r.pos_x = 6'(x);
      r.pos_y = 6'(y);
      r.opaque = opq;
      r.bit_mask = mask;
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(predict_rsp(r));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_clip(int l, int t, int r, int b);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_CLIP_LEFT;   csr_wdata <= 6'(l); @(posedge clock);
      csr_index <= CSR_CLIP_TOP;    csr_wdata <= 6'(t); @(posedge clock);
      csr_index <= CSR_CLIP_RIGHT;  csr_wdata <= 6'(r); @(posedge clock);
      csr_index <= CSR_CLIP_BOTTOM; csr_wdata <= 6'(b); @(posedge clock);
      csr_we <= 1'b0;
      clip_l = l; clip_t = t; clip_r = r; clip_b = b;
   endtask

   task automatic test_map_edges;
      send_item(CMD_READ, 0, 0, 0, 8'h00);
      send_item(CMD_READ, 63, 63, 0, 8'h00);
      send_item(CMD_WRITE, 0, 0, 1, 8'hFF);
      send_item(CMD_WRITE, 63, 63, 1, 8'h00);
      send_item(CMD_READ, 0, 0, 0, 8'h00);
      send_item(CMD_READ, 63, 63, 0, 8'h00);
      send_item(CMD_WRITE, 0, 0, 0, 8'h00);
      send_item(CMD_WRITE, 63, 63, 0, 8'hFF);
   endtask

   task automatic test_cast_full_map;
      send_item(CMD_WRITE, 33, 30, 1, 8'h00);
      send_item(CMD_WRITE, 30, 34, 1, 8'h00);
      send_item(CMD_CAST, 31, 31, 0, 8'hA5);
      send_item(CMD_READ, 40, 30, 0, 8'h00);
      send_item(CMD_READ, 63, 31, 0, 8'h00);
      send_item(CMD_CAST, 63, 0, 0, 8'h5A);
      send_item(CMD_READ, 0, 63, 0, 8'h00);
      send_item(CMD_CLEAR, 63, 63, 1, 8'h0F);
      send_item(CMD_READ, 31, 31, 0, 8'h00);
   endtask

   task automatic test_clip_cases;
      set_clip(20, 20, 27, 27);
      send_item(CMD_CAST, 5, 5, 0, 8'h01);
      send_item(CMD_CAST, 24, 24, 0, 8'h80);
      send_item(CMD_READ, 20, 27, 0, 8'h00);
      set_clip(63, 63, 63, 63);
      send_item(CMD_CAST, 63, 63, 0, 8'h02);
      send_item(CMD_READ, 63, 63, 0, 8'h00);
      set_clip(40, 40, 10, 10);
      send_item(CMD_CAST, 20, 20, 0, 8'hFF);
      send_item(CMD_CLEAR, 0, 0, 0, 8'hFF);
      send_item(CMD_READ, 31, 31, 0, 8'h00);
   endtask

   task automatic test_random(int count, int l, int t, int r, int b, int s_pct, int r_pct);
      int w, h, x, y, pick;
      set_clip(l, t, r, b);
      snd_idle_pct = s_pct;
      rcv_idle_pct = r_pct;
      w = r - l;
      h = b - t;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) < 8) begin
            x = l + $urandom_range(w);
            y = t + $urandom_range(h);
         end else begin
            x = $urandom_range(63);
            y = $urandom_range(63);
         end
         if (i == count / 2) drain();
         if (pick < 40)
            send_item(CMD_WRITE, x, y, $urandom_range(2) == 0, 8'($urandom_range(255)));
         else if (pick < 75)
            send_item(CMD_READ, x, y, 1'($urandom_range(1)), 8'($urandom_range(255)));
         else if (pick < 95)
            send_item(CMD_CAST, x, y, 1'($urandom_range(1)), 8'($urandom_range(255)));
         else
            send_item(CMD_CLEAR, x, y, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 18;
      rcv_idle_pct = 73;
      test_map_edges();
      test_cast_full_map();
      test_clip_cases();
      test_random(40, 10, 20, 25, 35, 18, 73);
      test_random(40, 0, 0, 15, 15, 73, 18);
      test_random(39, 48, 48, 63, 63, 0, 0);
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gfsr_pkg.sv
rtl/gfsr_slope.sv
rtl/grid_fov_slope_raycast.sv
bench/tb_top.sv
